FILE: src/lcdseq_pkg.sv
// shared types and constants for the character lcd nibble sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package lcdseq_pkg;

	// request kinds as seen on the input channel
	localparam logic [2:0] REQ_INIT  = 3'd0;
	localparam logic [2:0] REQ_CMD   = 3'd1;
	localparam logic [2:0] REQ_DATA  = 3'd2;
	localparam logic [2:0] REQ_CURSOR = 3'd3;
	localparam logic [2:0] REQ_GLYPH = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_SETTLE   = 2'd0;
	localparam logic [1:0] CFG_LONG_CMD = 2'd1;
	localparam logic [1:0] CFG_POWER_ON = 2'd2;

	// display command bytes and fixed waits
	localparam logic [7:0]  CMD_CLEAR      = 8'h01;
	localparam logic [7:0]  CMD_HOME       = 8'h02;
	localparam logic [7:0]  CMD_CGRAM_ADDR = 8'h40;
	localparam logic [7:0]  CMD_DDRAM_ADDR = 8'h80;
	localparam logic [7:0]  ROW1_BASE      = 8'h40;
	localparam logic [15:0] WAKE2_US       = 16'd5000;
	localparam logic [15:0] WAKE3_US       = 16'd150;
	localparam logic [3:0]  WAKE_NIB       = 4'h3;
	localparam logic [3:0]  FOUR_BIT_NIB   = 4'h2;

	// strobe counts, as index of the final strobe
	localparam logic [4:0] LAST_IDX_BYTE  = 5'd1;
	localparam logic [4:0] LAST_IDX_INIT  = 5'd13;
	localparam logic [4:0] LAST_IDX_GLYPH = 5'd17;
	localparam logic [4:0] INIT_WAKE_STROBES = 5'd4;
	localparam logic [4:0] GLYPH_HDR_STROBES = 5'd2;

	// classified work kinds held in the queue
	typedef enum logic [1:0] {
		KIND_INIT,
		KIND_CMD,
		KIND_DATA,
		KIND_GLYPH
	} seq_kind_t;

	typedef struct packed {
		seq_kind_t   kind;
		logic [7:0]  byte_val;
		logic [63:0] rows;
	} seq_item_t;

	typedef struct packed {
		logic        reg_select;
		logic [3:0]  nibble;
		logic [15:0] wait_before_us;
		logic [15:0] wait_after_us;
		logic        last;
	} strobe_t;

	// init command list after the wake nibbles
	function automatic logic [7:0] init_cmd(input logic [2:0] sel);
		logic [7:0] c;
		case (sel)
			3'd0:    c = 8'h28;
			3'd1:    c = 8'h08;
			3'd2:    c = 8'h01;
			3'd3:    c = 8'h06;
			3'd4:    c = 8'h0C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/lcdseq_front.sv
// front end: accepts requests and turns them into queue entries
// depends on lcdseq_pkg
`default_nettype none

module lcdseq_front import lcdseq_pkg::*; #(
	parameter int DISPLAY_COLUMNS = 16
) (
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  byte_value,
	input  wire logic [7:0]  column,
	input  wire logic [7:0]  row,
	input  wire logic [7:0]  glyph_slot,
	input  wire logic [63:0] glyph_rows,
	input  wire logic        q_full,
	output logic             push,
	output seq_item_t        push_item
);

	localparam logic [7:0] MAX_COL = 8'(DISPLAY_COLUMNS - 1);

	logic [7:0] col_c;
	logic [7:0] addr;
	logic       known;

	assign in_stall = q_full;

	always_comb begin
		col_c = (column > MAX_COL) ? MAX_COL : column;
		addr  = (col_c + ((row != 8'd0) ? ROW1_BASE : 8'd0)) & 8'h7F;
		known = 1'b1;
		push_item.rows     = glyph_rows;
		push_item.byte_val = byte_value;
		push_item.kind     = KIND_CMD;
		case (req_type)
			REQ_INIT: begin
				push_item.kind = KIND_INIT;
			end
			REQ_CMD: begin
				push_item.kind = KIND_CMD;
			end
			REQ_DATA: begin
				push_item.kind = KIND_DATA;
			end
			REQ_CURSOR: begin
				push_item.kind     = KIND_CMD;
				push_item.byte_val = CMD_DDRAM_ADDR | addr;
			end
			REQ_GLYPH: begin
				push_item.kind     = KIND_GLYPH;
				push_item.byte_val = CMD_CGRAM_ADDR | {2'b00, glyph_slot[2:0], 3'b000};
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// unknown kinds are accepted and dropped
	assign push = in_valid && !q_full && known;

endmodule

`default_nettype wire

FILE: src/lcdseq_queue.sv
// two-entry queue between front end and strobe sequencer
// depends on lcdseq_pkg
`default_nettype none

module lcdseq_queue import lcdseq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  seq_item_t       push_item,
	input  wire logic       pop,
	output logic            full,
	output logic            head_valid,
	output seq_item_t       head_item
);

	seq_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/lcdseq_back.sv
// back end: walks the strobes of the head entry into the output register
// depends on lcdseq_pkg
`default_nettype none

module lcdseq_back import lcdseq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [9:0]  settle_us,
	input  wire logic [15:0] long_command_us,
	input  wire logic [15:0] power_on_us,
	input  wire logic        head_valid,
	input  seq_item_t        head_item,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output strobe_t          out_strobe
);

	logic [4:0]  idx_q;
	logic        out_valid_q;
	strobe_t     out_q;
	strobe_t     strobe;
	logic        load;
	logic        is_byte;
	logic        is_long;
	logic [7:0]  byte_sel;
	logic [3:0]  wake_nib;
	logic [4:0]  last_idx;
	logic [4:0]  rel_idx;
	logic [16:0] after_sum;

	always_comb begin
		is_byte  = 1'b1;
		byte_sel = head_item.byte_val;
		wake_nib = WAKE_NIB;
		last_idx = LAST_IDX_BYTE;
		rel_idx  = 5'd0;
		strobe.reg_select     = 1'b0;
		strobe.wait_before_us = 16'd0;
		case (head_item.kind)
			KIND_INIT: begin
				last_idx = LAST_IDX_INIT;
				if (idx_q < INIT_WAKE_STROBES) begin
					is_byte = 1'b0;
					case (idx_q[1:0])
						2'd0:    strobe.wait_before_us = power_on_us;
						2'd1:    strobe.wait_before_us = WAKE2_US;
						2'd2:    strobe.wait_before_us = WAKE3_US;
						default: wake_nib = FOUR_BIT_NIB;
					endcase
				end else begin
					rel_idx  = idx_q - INIT_WAKE_STROBES;
					byte_sel = init_cmd(rel_idx[3:1]);
				end
			end
			KIND_DATA: begin
				strobe.reg_select = 1'b1;
			end
			KIND_GLYPH: begin
				last_idx = LAST_IDX_GLYPH;
				if (idx_q >= GLYPH_HDR_STROBES) begin
					rel_idx           = idx_q - GLYPH_HDR_STROBES;
					strobe.reg_select = 1'b1;
					byte_sel          = head_item.rows[{rel_idx[3:1], 3'b000} +: 8];
				end
			end
			default: begin
			end
		endcase
		// even strobe carries the high nibble
		strobe.nibble = !is_byte ? wake_nib :
		                (idx_q[0] ? byte_sel[3:0] : byte_sel[7:4]);
		is_long = is_byte && !strobe.reg_select && idx_q[0] &&
		          (byte_sel == CMD_CLEAR || byte_sel == CMD_HOME);
		after_sum = {7'd0, settle_us} + (is_long ? {1'b0, long_command_us} : 17'd0);
		strobe.wait_after_us = after_sum[16] ? 16'hFFFF : after_sum[15:0];
		strobe.last = (idx_q == last_idx);
	end

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && strobe.last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= strobe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				idx_q <= strobe.last ? 5'd0 : idx_q + 5'd1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_strobe = out_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX_GLYPH)
		else $error("strobe index past longest request");

	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 5'd0)
		else $error("strobe index not cleared after final strobe");

	a_data_rs: assert property (@(posedge clk) disable iff (!arst_n)
		load && head_item.kind == KIND_DATA |=> out_q.reg_select)
		else $error("data strobe sent to command register");

endmodule

`default_nettype wire

FILE: src/char_lcd_nibble_sequencer_core.sv
// top level of the character lcd nibble sequencer
// depends on lcdseq_pkg, lcdseq_front, lcdseq_queue and lcdseq_back
`default_nettype none

// Turns host requests (init, command, data, set cursor, define glyph) into
// 4-bit enable strobes for an hd44780-style display. Each output beat is one
// strobe: register select, nibble, wait before enable rises, wait after it
// falls (saturated at 65535 us), and last on the final strobe of a request.
// Byte requests give 2 strobes, init 14, glyph 18; unknown kinds are taken
// and give none. The sequencer emits one strobe per cycle when the output
// is not stalled; a two-entry request queue lets the input keep accepting
// while earlier requests are still being strobed out.
// Configuration writes should only be made while no request is in flight.
module char_lcd_nibble_sequencer_core import lcdseq_pkg::*; #(
	parameter int DISPLAY_COLUMNS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  byte_value,
	input  wire logic [7:0]  column,
	input  wire logic [7:0]  row,
	input  wire logic [7:0]  glyph_slot,
	input  wire logic [63:0] glyph_rows,
	// strobe channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             reg_select,
	output logic [3:0]       nibble,
	output logic [15:0]      wait_before_us,
	output logic [15:0]      wait_after_us,
	output logic             last
);

	// timing registers
	logic [9:0]  settle_q;
	logic [15:0] long_cmd_q;
	logic [15:0] power_on_q;

	// queue handshake between the two halves
	logic        q_push;
	seq_item_t   q_push_item;
	logic        q_full;
	logic        q_pop;
	logic        q_head_valid;
	seq_item_t   q_head_item;
	strobe_t     strobe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q   <= 10'd50;
			long_cmd_q <= 16'd2000;
			power_on_q <= 16'd50000;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SETTLE:   settle_q   <= cfg_data[9:0];
				CFG_LONG_CMD: long_cmd_q <= cfg_data;
				CFG_POWER_ON: power_on_q <= cfg_data;
				default: begin
					// index beyond the register list is ignored
				end
			endcase
		end
	end

	// front end: classify and build the cursor and glyph address commands
	lcdseq_front #(
		.DISPLAY_COLUMNS(DISPLAY_COLUMNS)
	) u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.byte_value(byte_value),
		.column    (column),
		.row       (row),
		.glyph_slot(glyph_slot),
		.glyph_rows(glyph_rows),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (q_push_item)
	);

	// decoupling queue
	lcdseq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.full      (q_full),
		.head_valid(q_head_valid),
		.head_item (q_head_item)
	);

	// back end: one strobe per cycle into the output register while the output is not stalled
	lcdseq_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.settle_us      (settle_q),
		.long_command_us(long_cmd_q),
		.power_on_us    (power_on_q),
		.head_valid     (q_head_valid),
		.head_item      (q_head_item),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_strobe     (strobe)
	);

	assign reg_select     = strobe.reg_select;
	assign nibble         = strobe.nibble;
	assign wait_before_us = strobe.wait_before_us;
	assign wait_after_us  = strobe.wait_after_us;
	assign last           = strobe.last;

endmodule

`default_nettype wire

FILE: tb/tb_char_lcd_nibble_sequencer_core.sv
// self-checking testbench for char_lcd_nibble_sequencer_core
// holds a strobe scoreboard class and the drivers; depends on lcdseq_pkg and the core
`default_nettype none

module tb_char_lcd_nibble_sequencer_core;
	import lcdseq_pkg::*;

	localparam int COLUMNS        = 16;
	localparam int HALF_PERIOD    = 10;
	localparam int TIMEOUT_CYCLES = 400000;
	// cycles allowed after the last strobe before the block counts as idle
	localparam int QUIET_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 300;
	localparam int KNOWN_PER_PHASE = 19;

	// request kinds the block takes but ignores
	localparam logic [2:0] REQ_RSVD_A = 3'd5;
	localparam logic [2:0] REQ_RSVD_B = 3'd6;
	localparam logic [2:0] REQ_RSVD_C = 3'd7;
	// register index past the end of the register list
	localparam logic [1:0] CFG_NONE = 2'd3;

	// function set, display off, clear, entry mode, display on
	localparam logic [39:0] INIT_CMD_LIST = {8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  byte_value;
		logic [7:0]  column;
		logic [7:0]  row;
		logic [7:0]  slot;
		logic [63:0] rows;
	} lcd_req_t;

	// expected strobe runs, built per accepted request, checked in order
	class strobe_board;
		int unsigned settle;
		int unsigned long_cmd;
		int unsigned power_on;
		strobe_t     due[$];
		strobe_t     run[$];
		int          errors;
		int          shown;

		function new();
			settle   = 50;
			long_cmd = 2000;
			power_on = 50000;
			errors   = 0;
			shown    = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [15:0] d);
			case (idx)
				CFG_SETTLE:   settle = d & 16'h03FF;
				CFG_LONG_CMD: long_cmd = d;
				CFG_POWER_ON: power_on = d;
				default: ;
			endcase
		endfunction

		function void add(logic rs, logic [3:0] nib, int unsigned pre_us,
				int unsigned after);
			strobe_t s;
			s.reg_select     = rs;
			s.nibble         = nib;
			s.wait_before_us = 16'(pre_us);
			s.wait_after_us  = (after > 65535) ? 16'hFFFF : 16'(after);
			s.last           = 1'b0;
			run.push_back(s);
		endfunction

		function void add_byte(logic [7:0] v, logic rs, int unsigned extra);
			add(rs, v[7:4], 0, settle);
			add(rs, v[3:0], 0, settle + extra);
		endfunction

		function void add_cmd(logic [7:0] c);
			add_byte(c, 1'b0, (c == CMD_CLEAR || c == CMD_HOME) ? long_cmd : 0);
		endfunction

		function void note_request(lcd_req_t r);
			logic [7:0] col;
			logic [7:0] base;
			strobe_t    tail;
			run.delete();
			case (r.kind)
				REQ_INIT: begin
					add(1'b0, WAKE_NIB, power_on, settle);
					add(1'b0, WAKE_NIB, WAKE2_US, settle);
					add(1'b0, WAKE_NIB, WAKE3_US, settle);
					add(1'b0, FOUR_BIT_NIB, 0, settle);
					for (int i = 0; i < 5; i++)
						add_cmd(INIT_CMD_LIST[39 - 8 * i -: 8]);
				end
				REQ_CMD:  add_cmd(r.byte_value);
				REQ_DATA: add_byte(r.byte_value, 1'b1, 0);
				REQ_CURSOR: begin
					// column clamps to the last one, any row above 1 means row 1
					col  = (r.column > COLUMNS - 1) ? 8'(COLUMNS - 1) : r.column;
					base = (r.row != 8'd0) ? ROW1_BASE : 8'h00;
					add_cmd(CMD_DDRAM_ADDR | ((col + base) & 8'h7F));
				end
				REQ_GLYPH: begin
					add_cmd(CMD_CGRAM_ADDR | {2'b00, r.slot[2:0], 3'b000});
					for (int i = 0; i < 8; i++)
						add_byte(r.rows[8 * i +: 8], 1'b1, 0);
				end
				default: ;
			endcase
			if (run.size() > 0) begin
				tail = run[run.size() - 1];
				tail.last = 1'b1;
				run[run.size() - 1] = tail;
			end
			foreach (run[i])
				due.push_back(run[i]);
		endfunction

		task report(string msg);
			errors++;
			if (shown < 40) begin
				$display("mismatch at %0t: %s", $realtime, msg);
				shown++;
			end
		endtask

		task check_strobe(strobe_t got);
			strobe_t want;
			if (due.size() == 0) begin
				report("strobe beat with nothing expected");
			end else begin
				want = due.pop_front();
				if (got.reg_select !== want.reg_select)
					report($sformatf("reg_select %b, want %b", got.reg_select,
						want.reg_select));
				if (got.nibble !== want.nibble)
					report($sformatf("nibble %h, want %h", got.nibble, want.nibble));
				if (got.wait_before_us !== want.wait_before_us)
					report($sformatf("wait_before_us %0d, want %0d",
						got.wait_before_us, want.wait_before_us));
				if (got.wait_after_us !== want.wait_after_us)
					report($sformatf("wait_after_us %0d, want %0d",
						got.wait_after_us, want.wait_after_us));
				if (got.last !== want.last)
					report($sformatf("last %b, want %b", got.last, want.last));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = '0;
	logic [7:0]  byte_value = '0;
	logic [7:0]  column = '0;
	logic [7:0]  row = '0;
	logic [7:0]  glyph_slot = '0;
	logic [63:0] glyph_rows = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        reg_select;
	logic [3:0]  nibble;
	logic [15:0] wait_before_us;
	logic [15:0] wait_after_us;
	logic        last;

	strobe_board sb = new();

	// sender pacing: beats left in the current burst
	int burst_left = 0;
	// long receiver hold-offs asked by the stimulus and served by the receiver
	int hold_asked = 0;
	int hold_served = 0;

	char_lcd_nibble_sequencer_core #(
		.DISPLAY_COLUMNS(COLUMNS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.byte_value(byte_value),
		.column(column),
		.row(row),
		.glyph_slot(glyph_slot),
		.glyph_rows(glyph_rows),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.reg_select(reg_select),
		.nibble(nibble),
		.wait_before_us(wait_before_us),
		.wait_after_us(wait_after_us),
		.last(last)
	);

	initial begin
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
		$display("timeout with %0d strobes still due", sb.due.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic lcd_req_t mk(logic [2:0] kind, logic [7:0] bv, logic [7:0] col,
			logic [7:0] rw, logic [7:0] slot, logic [63:0] rows);
		lcd_req_t r;
		r.kind       = kind;
		r.byte_value = bv;
		r.column     = col;
		r.row        = rw;
		r.slot       = slot;
		r.rows       = rows;
		return r;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// mostly well-formed requests with random content, a tenth ignored kinds;
	// fields a kind does not use are always random
	function automatic lcd_req_t random_req();
		lcd_req_t r;
		int       pick;
		r = mk(REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			rnd64());
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			r.kind = REQ_INIT;
		end else if (pick < 33) begin
			r.kind = REQ_CMD;
			// clear and home carry the long wait, so hit them often
			case ($urandom_range(0, 7))
				0: r.byte_value = CMD_CLEAR;
				1: r.byte_value = CMD_HOME;
				default: ;
			endcase
		end else if (pick < 58) begin
			r.kind = REQ_DATA;
		end else if (pick < 75) begin
			r.kind = REQ_CURSOR;
			if ($urandom_range(0, 1) == 0)
				r.column = 8'($urandom_range(0, COLUMNS + 4));
			if ($urandom_range(0, 1) == 0)
				r.row = 8'($urandom_range(0, 2));
		end else if (pick < 90) begin
			r.kind = REQ_GLYPH;
		end else begin
			case ($urandom_range(0, 2))
				0: r.kind = REQ_RSVD_A;
				1: r.kind = REQ_RSVD_B;
				default: r.kind = REQ_RSVD_C;
			endcase
		end
		return r;
	endfunction

	// present one request beat and hold it until the block takes it
	task automatic send_req(lcd_req_t r);
		@(negedge clk);
		in_valid   <= 1'b1;
		req_type   <= r.kind;
		byte_value <= r.byte_value;
		column     <= r.column;
		row        <= r.row;
		glyph_slot <= r.slot;
		glyph_rows <= r.rows;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
	endtask

	// burst pacing: at the end of a burst drop valid for a random gap
	task automatic offer(lcd_req_t r);
		int gap;
		send_req(r);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 5) == 0) ? 25 : $urandom_range(1, 8);
		end
	endtask

	// stop offering and wait until every expected strobe has come out
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [15:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		sb.set_register(idx, d);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic random_phase();
		lcd_req_t r;
		int       known;
		known = 0;
		while (known < KNOWN_PER_PHASE) begin
			r = random_req();
			if (r.kind <= REQ_GLYPH)
				known++;
			offer(r);
		end
	endtask

	// strobe channel monitor: one check per accepted beat
	always @(posedge clk) begin : take_strobe
		strobe_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.reg_select     = reg_select;
			got.nibble         = nibble;
			got.wait_before_us = wait_before_us;
			got.wait_after_us  = wait_after_us;
			got.last           = last;
			sb.check_strobe(got);
		end
	end

	// receiver: stall pattern in segments of random length and density,
	// plus the long hold-off when the stimulus asks for one
	initial begin : receiver
		int seg;
		int mode;
		@(posedge arst_n);
		forever begin
			if (hold_asked != hold_served) begin
				hold_served++;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			seg  = $urandom_range(10, 60);
			mode = $urandom_range(0, 2);
			repeat (seg) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		burst_left = $urandom_range(1, 8);

		// directed part under the reset register values
		offer(mk(REQ_INIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1));
		offer(mk(REQ_CMD, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom), rnd64()));
		offer(mk(REQ_CMD, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), rnd64()));
		offer(mk(REQ_CMD, CMD_CLEAR, 8'h00, 8'h00, 8'h00, '0));
		offer(mk(REQ_CMD, CMD_HOME, 8'($urandom), 8'($urandom), 8'($urandom), rnd64()));
		offer(mk(REQ_CMD, 8'h03, 8'($urandom), 8'($urandom), 8'($urandom), rnd64()));
		offer(mk(REQ_DATA, 8'h00, 8'hFF, 8'hFF, 8'hFF, '1));
		offer(mk(REQ_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, '0));
		// cursor corners, then clamping of column and row
		offer(mk(REQ_CURSOR, 8'($urandom), 8'd0, 8'd0, 8'($urandom), rnd64()));
		offer(mk(REQ_CURSOR, 8'($urandom), 8'd15, 8'd1, 8'($urandom), rnd64()));
		offer(mk(REQ_CURSOR, 8'($urandom), 8'd16, 8'd0, 8'($urandom), rnd64()));
		offer(mk(REQ_CURSOR, 8'($urandom), 8'd255, 8'd255, 8'($urandom), rnd64()));
		offer(mk(REQ_CURSOR, 8'($urandom), 8'd7, 8'd2, 8'($urandom), rnd64()));
		// glyph slots: zero, all ones, and one past the three slot bits
		offer(mk(REQ_GLYPH, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0, '0));
		offer(mk(REQ_GLYPH, 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF, '1));
		offer(mk(REQ_GLYPH, 8'($urandom), 8'($urandom), 8'($urandom), 8'd8,
			64'h0123_4567_89AB_CDEF));
		// ignored kinds must give no strobes at all
		offer(mk(REQ_RSVD_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1));
		offer(mk(REQ_RSVD_B, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			rnd64()));
		offer(mk(REQ_RSVD_C, 8'h00, 8'h00, 8'h00, 8'h00, '0));
		offer(mk(REQ_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			rnd64()));
		random_phase();
		quiesce();

		// all waits zero; long receiver hold-off part way in
		write_register(CFG_SETTLE, 16'd0);
		write_register(CFG_LONG_CMD, 16'd0);
		write_register(CFG_POWER_ON, 16'd0);
		end_writes();
		offer(mk(REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			rnd64()));
		offer(mk(REQ_CMD, CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), rnd64()));
		hold_asked++;
		random_phase();
		quiesce();

		// largest values: settle written with spare high bits, clear saturates
		write_register(CFG_SETTLE, 16'hFFFF);
		write_register(CFG_LONG_CMD, 16'hFFFF);
		write_register(CFG_POWER_ON, 16'hFFFF);
		end_writes();
		offer(mk(REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			rnd64()));
		offer(mk(REQ_CMD, CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), rnd64()));
		offer(mk(REQ_CMD, CMD_HOME, 8'($urandom), 8'($urandom), 8'($urandom), rnd64()));
		random_phase();
		quiesce();

		// random values, and a write to an index with no register behind it
		write_register(CFG_SETTLE, 16'($urandom));
		write_register(CFG_LONG_CMD, 16'($urandom));
		write_register(CFG_POWER_ON, 16'($urandom));
		write_register(CFG_NONE, 16'($urandom));
		end_writes();
		offer(mk(REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			rnd64()));
		random_phase();
		quiesce();

		if (sb.due.size() != 0)
			sb.report($sformatf("%0d strobes never came out", sb.due.size()));
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: char_lcd_nibble_sequencer_core.f
src/lcdseq_pkg.sv
src/lcdseq_front.sv
src/lcdseq_queue.sv
src/lcdseq_back.sv
src/char_lcd_nibble_sequencer_core.sv
tb/tb_char_lcd_nibble_sequencer_core.sv
